[rtl/spm_pkg.sv]
// Package for the sparse polynomial multiply unit.
// Holds field widths, sizing constants and term opcodes; no dependencies.
`default_nettype none
package spm_pkg;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned ExpW     = 10;
  localparam int unsigned SumW     = 38;
  localparam int unsigned SumExpW  = 11;
  localparam int unsigned MaxTerms = 8;

  // Opcode carried with each loaded term
  localparam logic OpFirst  = 1'b0;
  localparam logic OpSecond = 1'b1;
endpackage
`default_nettype wire

[rtl/sparse_polynomial_multiply_unit.sv]
// Sparse polynomial multiply unit: term stores, pair scans and result output.
// Depends on spm_pkg.
`default_nettype none
// Terms arrive one per transaction (opcode 0: first polynomial, 1: second);
// a term beyond MAX_TERMS for its polynomial is dropped. A second-polynomial
// term with tlast set starts the product; an empty first polynomial gives no
// results. The product is formed in passes, one per distinct exponent sum,
// highest first: each pass reads every pair of terms from the term memories,
// one pair a cycle, and keeps the largest exponent sum below the previous
// result together with the running sum of its coefficients. Each pass then
// drains the read and multiply stages and loads the result register, waiting
// on any output stall. No input is taken from the final term until the last
// result is loaded into the output register. Zero sums are emitted like any
// other.
module sparse_polynomial_multiply_unit #(
  parameter int unsigned MAX_TERMS = spm_pkg::MaxTerms
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // tdata: coefficient[15:0], exponent[25:16], zero fill [31:26]
  input  wire logic [31:0] s_axis_tdata_i,
  // tuser: opcode
  input  wire logic        s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: sum_coefficient[37:0], sum_exponent[48:38], zero fill [55:49]
  output      logic [55:0] m_axis_tdata_o,
  output      logic        m_axis_tlast_o
);
  localparam int unsigned IdxW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CntW    = $clog2(MAX_TERMS + 1);
  localparam int unsigned CoefW   = spm_pkg::CoefW;
  localparam int unsigned ExpW    = spm_pkg::ExpW;
  localparam int unsigned SumW    = spm_pkg::SumW;
  localparam int unsigned SumExpW = spm_pkg::SumExpW;
  localparam int unsigned ProdW   = 2 * CoefW;

  typedef enum logic [3:0] {
    StLoad  = 4'b0001,
    StPass  = 4'b0010,
    StDrain = 4'b0100,
    StEmit  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_a_q, cnt_b_q;
  logic [IdxW-1:0] ia_q, ib_q;
  logic signed [CoefW-1:0] ca_mem [MAX_TERMS];
  logic signed [CoefW-1:0] cb_mem [MAX_TERMS];
  logic [ExpW-1:0] ea_mem [MAX_TERMS];
  logic [ExpW-1:0] eb_mem [MAX_TERMS];
  logic signed [CoefW-1:0] rca_q, rcb_q;
  logic [ExpW-1:0] rea_q, reb_q;
  logic rv_q;
  logic signed [ProdW-1:0] pc_q;
  logic [SumExpW-1:0] pe_q;
  logic pv_q;
  logic [SumExpW:0] bound_q;
  logic [SumExpW-1:0] max_e_q;
  logic signed [SumW-1:0] sum_q;
  logic have_max_q, lower_q;
  logic signed [SumW-1:0] out_c_q;
  logic [SumExpW-1:0] out_e_q;
  logic out_v_q, out_l_q;

  logic in_fire, in_first, in_second, load_a, load_b, start;
  logic out_free, emit, finish, start_pass;
  logic last_a, last_b;
  logic signed [CoefW-1:0] in_coef;
  logic [ExpW-1:0] in_exp;

  assign in_coef = s_axis_tdata_i[15:0];
  assign in_exp  = s_axis_tdata_i[25:16];
  assign s_axis_tready_o = (state_q == StLoad);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_first  = in_fire && (s_axis_tuser_i == spm_pkg::OpFirst);
  assign in_second = in_fire && (s_axis_tuser_i == spm_pkg::OpSecond);
  assign load_a = in_first && (cnt_a_q < CntW'(MAX_TERMS));
  assign load_b = in_second && (cnt_b_q < CntW'(MAX_TERMS));
  assign start  = in_second && s_axis_tlast_i;
  assign out_free   = !out_v_q || m_axis_tready_i;
  assign emit       = (state_q == StEmit) && out_free;
  assign finish     = emit && !lower_q;
  assign start_pass = (start && (cnt_a_q != '0)) || (emit && lower_q);
  assign last_a = (CntW'(ia_q) == CntW'(cnt_a_q - 1'b1));
  assign last_b = (CntW'(ib_q) == CntW'(cnt_b_q - 1'b1));

  // Term memories: write on load, read one pair a cycle during a pass;
  // loads and passes never overlap, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (load_a) begin
      ca_mem[cnt_a_q[IdxW-1:0]] <= in_coef;
      ea_mem[cnt_a_q[IdxW-1:0]] <= in_exp;
    end
    if (load_b) begin
      cb_mem[cnt_b_q[IdxW-1:0]] <= in_coef;
      eb_mem[cnt_b_q[IdxW-1:0]] <= in_exp;
    end
    if (state_q == StPass) begin
      rca_q <= ca_mem[ia_q];
      rea_q <= ea_mem[ia_q];
      rcb_q <= cb_mem[ib_q];
      reb_q <= eb_mem[ib_q];
    end
  end

  // Multiply coefficients and add exponents of the pair just read
  always_ff @(posedge clk_i) begin
    pc_q <= ProdW'(rca_q) * ProdW'(rcb_q);
    pe_q <= SumExpW'(rea_q) + SumExpW'(reb_q);
  end

  // Advance the pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      pv_q <= 1'b0;
    end else begin
      rv_q <= (state_q == StPass);
      pv_q <= rv_q;
    end
  end

  // Track the largest exponent below the bound and sum its coefficients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_max_q <= 1'b0;
      lower_q    <= 1'b0;
      max_e_q    <= '0;
      sum_q      <= '0;
      bound_q    <= '0;
    end else if (start_pass) begin
      have_max_q <= 1'b0;
      lower_q    <= 1'b0;
      bound_q    <= (state_q == StEmit) ? {1'b0, max_e_q} : {1'b1, {SumExpW{1'b0}}};
    end else if (pv_q && ({1'b0, pe_q} < bound_q)) begin
      if (!have_max_q || (pe_q > max_e_q)) begin
        have_max_q <= 1'b1;
        lower_q    <= lower_q || have_max_q;
        max_e_q    <= pe_q;
        sum_q      <= SumW'(pc_q);
      end else if (pe_q == max_e_q) begin
        sum_q <= sum_q + SumW'(pc_q);
      end else begin
        lower_q <= 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (start_pass) state_d = StPass;
      end
      StPass: begin
        if (last_a && last_b) state_d = StDrain;
      end
      StDrain: begin
        if (!rv_q) state_d = StEmit;
      end
      StEmit: begin
        if (emit) state_d = lower_q ? StPass : StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  // State, term counts and pair indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ia_q    <= '0;
      ib_q    <= '0;
    end else begin
      state_q <= state_d;
      // drop both polynomials once the product is done or has no terms
      if (finish || (start && (cnt_a_q == '0))) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
      end else begin
        if (load_a) cnt_a_q <= cnt_a_q + 1'b1;
        if (load_b) cnt_b_q <= cnt_b_q + 1'b1;
      end
      // step through every pair, second polynomial fastest
      if (start_pass) begin
        ia_q <= '0;
        ib_q <= '0;
      end else if (state_q == StPass) begin
        if (last_b) begin
          ib_q <= '0;
          ia_q <= ia_q + 1'b1;
        end else begin
          ib_q <= ib_q + 1'b1;
        end
      end
    end
  end

  // Output register: load a result when free, hold it while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      out_l_q <= 1'b0;
      out_c_q <= '0;
      out_e_q <= '0;
    end else if (emit) begin
      out_v_q <= 1'b1;
      out_l_q <= !lower_q;
      out_c_q <= sum_q;
      out_e_q <= max_e_q;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tlast_o  = out_l_q;
  assign m_axis_tdata_o  = {7'b0, out_e_q, out_c_q};

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CntW'(MAX_TERMS)) && (cnt_b_q <= CntW'(MAX_TERMS)))
    else $error("term count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (!rv_q && !pv_q))
    else $error("result taken before the pass drained");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPass) |-> ((cnt_a_q != '0) && (cnt_b_q != '0)))
    else $error("pass over an empty polynomial");
`endif
endmodule
`default_nettype wire

[test/spm_checker.sv]
// Checker for the sparse polynomial multiply unit: watches both streams,
// predicts the merged product terms and compares them. Depends on spm_pkg.
`default_nettype none
module spm_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [31:0] s_tdata_i,
  input  wire logic        s_tuser_i,
  input  wire logic        s_tlast_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [55:0] m_tdata_i,
  input  wire logic        m_tlast_i,
  output int               errors_o,
  output int               pending_o
);
  localparam int unsigned SumW     = spm_pkg::SumW;
  localparam int unsigned SumExpW  = spm_pkg::SumExpW;
  localparam int unsigned MaxTerms = spm_pkg::MaxTerms;

  typedef struct packed {
    logic signed [spm_pkg::SumW-1:0] coef;
    logic [spm_pkg::SumExpW-1:0]     expo;
    logic                            last;
  } term_t;

  logic signed [spm_pkg::CoefW-1:0] a_coef[spm_pkg::MaxTerms], b_coef[spm_pkg::MaxTerms];
  logic [spm_pkg::ExpW-1:0]         a_exp[spm_pkg::MaxTerms], b_exp[spm_pkg::MaxTerms];
  int                               a_cnt, b_cnt;
  term_t                            product_terms[$];

  // Multiply the loaded pair and queue one term per distinct exponent, highest first
  task automatic multiply_polys();
    logic signed [spm_pkg::SumW-1:0] acc[int];
    int                              e;
    term_t                           t;
    for (int i = 0; i < a_cnt; i++)
      for (int j = 0; j < b_cnt; j++) begin
        e = int'(a_exp[i]) + int'(b_exp[j]);
        if (!acc.exists(e)) acc[e] = '0;
        acc[e] = acc[e] + SumW'(a_coef[i]) * SumW'(b_coef[j]);
      end
    for (int x = 2046; x >= 0; x--)
      if (acc.exists(x)) begin
        t.coef = acc[x];
        t.expo = SumExpW'(x);
        t.last = 1'b0;
        product_terms.push_back(t);
      end
    if (acc.num() > 0) product_terms[$].last = 1'b1;
    a_cnt = 0;
    b_cnt = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    term_t got, want;
    if (!rst_ni) begin
      a_cnt = 0;
      b_cnt = 0;
      product_terms.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      // Load an input transaction; drop terms beyond capacity
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == spm_pkg::OpFirst) begin
          if (a_cnt < MaxTerms) begin
            a_coef[a_cnt] = s_tdata_i[15:0];
            a_exp[a_cnt] = s_tdata_i[25:16];
            a_cnt = a_cnt + 1;
          end
        end else begin
          if (b_cnt < MaxTerms) begin
            b_coef[b_cnt] = s_tdata_i[15:0];
            b_exp[b_cnt] = s_tdata_i[25:16];
            b_cnt = b_cnt + 1;
          end
          if (s_tlast_i) multiply_polys();
        end
      end
      // Compare an output transaction with the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        got.coef = m_tdata_i[37:0];
        got.expo = m_tdata_i[48:38];
        got.last = m_tlast_i;
        if (product_terms.size() == 0) begin
          $display("%0t: unexpected term expected none actual %0d x^%0d last %0b",
                   $time, got.coef, got.expo, got.last);
          errors_o <= errors_o + 1;
        end else begin
          want = product_terms.pop_front();
          if (got != want || m_tdata_i[55:49] != '0) begin
            $display("%0t: mismatch expected %0d x^%0d last %0b",
                     $time, want.coef, want.expo, want.last,
                     " actual %0d x^%0d last %0b", got.coef, got.expo, got.last);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= product_terms.size();
    end
  end
endmodule
`default_nettype wire

[test/tb_top.sv]
// Testbench top for the sparse polynomial multiply unit: clock, reset,
// term stimulus and verdict. Depends on spm_pkg and spm_checker.
`default_nettype none
module tb_top;
  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  int          errors, pending;
  int          idle_pct = 25;
  bit          hold_off = 1'b0;
  int          quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sparse_polynomial_multiply_unit u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tlast_o(m_tlast)
  );

  spm_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .s_tuser_i(s_tuser), .s_tlast_i(s_tlast),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .m_tlast_i(m_tlast), .errors_o(errors), .pending_o(pending)
  );

  // Drive the receiver ready, stalling at random unless held off
  always @(posedge clk_i)
    m_tready <= !hold_off && ($urandom_range(99) >= idle_pct);

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one term and wait for its transaction
  task automatic send_term(bit op, logic [15:0] coef, logic [9:0] expo, bit fin);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, expo, coef};
    s_tlast  <= fin;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Load a random pair of polynomials, mostly well formed
  task automatic send_pair(int na, int nb, bit narrow);
    logic [9:0] e;
    for (int i = 0; i < na; i++) begin
      e = narrow ? 10'($urandom_range(7)) : 10'($urandom);
      send_term(spm_pkg::OpFirst, 16'($urandom), e, $urandom_range(3) == 0);
    end
    for (int j = 0; j < nb; j++) begin
      e = narrow ? 10'($urandom_range(7)) : 10'($urandom);
      send_term(spm_pkg::OpSecond, 16'($urandom), e, j == nb - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single product at extremes
    send_term(spm_pkg::OpFirst, 16'h8000, 10'h3ff, 1'b1);
    send_term(spm_pkg::OpSecond, 16'h8000, 10'h3ff, 1'b1);
    send_term(spm_pkg::OpFirst, 16'h7fff, 10'h000, 1'b0);
    send_term(spm_pkg::OpSecond, 16'h8000, 10'h000, 1'b1);
    // Empty first polynomial yields nothing
    send_term(spm_pkg::OpSecond, 16'h0001, 10'h005, 1'b1);
    // Cancellation to zero and merged exponents
    send_term(spm_pkg::OpFirst, 16'h0001, 10'h001, 1'b0);
    send_term(spm_pkg::OpFirst, 16'hffff, 10'h001, 1'b0);
    send_term(spm_pkg::OpSecond, 16'h0003, 10'h002, 1'b1);
    // Full polynomials with surplus terms dropped, all extremes merged
    for (int i = 0; i < 9; i++) send_term(spm_pkg::OpFirst, 16'h8000, 10'h3ff, 1'b0);
    for (int i = 0; i < 9; i++) send_term(spm_pkg::OpSecond, 16'h8000, 10'h3ff, i == 8);
    sent = 26;

    // Back-pressure: hold the receiver off while sets queue up
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_pair(3, 3, 1'b1);
        send_pair(2, 4, 1'b0);
      end
    join
    sent += 12;

    // Random: a quiet stretch first, then normal idling
    idle_pct = 0;
    while (sent < 270) begin
      int na, nb, maxn;
      if (sent > 80) idle_pct = 25;
      maxn = ($urandom_range(7) == 0) ? 9 : 4;
      na = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, maxn);
      maxn = ($urandom_range(7) == 0) ? 9 : 4;
      nb = $urandom_range(1, maxn);
      send_pair(na, nb, $urandom_range(1));
      sent += na + nb;
    end
    s_tvalid <= 1'b0;

    // Drain the expected results, then watch for stray ones
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
